FILE: rtl/core/dad_pkg.sv
`timescale 1ns / 1ps

package dad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFFS_W  = 11;
    localparam int STAT_W  = 2;
    // shared adder width: holds a year during the remainder search and a walking day
    localparam int ACC_W   = 16;
    // walking day: 1..31 plus an offset of -1024..1023
    localparam int WDAY_W  = 12;
    localparam int QBIT_W  = 3;

    localparam int YEAR_MAX   = 9999;
    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int Q_TOP      = 5;

    localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(0);
    localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(11);

    localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_INVALID = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_RANGE   = STAT_W'(2);

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [STAT_W-1:0]  status;
    } t_result;

    typedef struct packed {
        logic start;
        logic take;
    } t_seq_req;

    typedef struct packed {
        logic ready;
        logic done;
    } t_seq_rsp;

    // days per month, february stretched in leap years
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1:                   len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd3, 4'd5, 4'd8, 4'd10: len = DAY_W'(30);
            default:                len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/dad_if.sv
`timescale 1ns / 1ps

interface dad_in_if import dad_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [YEAR_W-1:0]         start_year;
    logic [MONTH_W-1:0]        start_month;
    logic [DAY_W-1:0]          start_day;
    logic signed [OFFS_W-1:0]  day_offset;

    modport source (output valid, start_year, start_month, start_day, day_offset,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_offset,
                    output ready);
endinterface

interface dad_out_if import dad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic [STAT_W-1:0]  status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

FILE: rtl/core/dad_alu.sv
`timescale 1ns / 1ps

module dad_alu import dad_pkg::*; (
    input  logic signed [ACC_W-1:0] i_a,
    input  logic signed [ACC_W-1:0] i_b,
    input  logic                    i_sub,
    output logic signed [ACC_W-1:0] o_sum,
    output logic                    o_neg,
    output logic                    o_zero
);

    assign o_sum  = i_sub ? (i_a - i_b) : (i_a + i_b);
    assign o_neg  = o_sum[ACC_W-1];
    assign o_zero = (o_sum == '0);

endmodule

FILE: rtl/core/dad_seq.sv
`timescale 1ns / 1ps

module dad_seq import dad_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_seq_req                 i_req,
    input  logic [YEAR_W-1:0]        i_year,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic signed [OFFS_W-1:0] i_offs,
    output t_seq_rsp                 o_rsp,
    output t_result                  o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                    r_state;
    logic signed [ACC_W-1:0]   r_year;
    logic [YEAR_W-1:0]         r_rem;
    logic [QBIT_W-1:0]         r_qbit;
    logic [MONTH_W-1:0]        r_month;
    logic signed [WDAY_W-1:0]  r_day;
    t_result                   r_res;

    logic signed [ACC_W-1:0] alu_a, alu_b, alu_sum;
    logic                    alu_sub, alu_neg, alu_zero;
    logic                    leap, day_low, fwd;
    logic [MONTH_W-1:0]      prev_m, next_m;
    logic [DAY_W-1:0]        dim_cur, dim_prev;
    logic [YEAR_W-1:0]       rem_inc, rem_dec;

    // year mod 400 leap rule
    assign leap = (r_rem == '0) ||
                  ((r_rem[1:0] == 2'b00) && (r_rem != YEAR_W'(CENTURY)) &&
                   (r_rem != YEAR_W'(2 * CENTURY)) && (r_rem != YEAR_W'(3 * CENTURY)));

    assign prev_m   = (r_month == MON_JAN) ? MON_DEC : r_month - MONTH_W'(1);
    assign next_m   = (r_month == MON_DEC) ? MON_JAN : r_month + MONTH_W'(1);
    assign dim_cur  = days_in(r_month, leap);
    assign dim_prev = days_in(prev_m, leap);
    assign day_low  = r_day[WDAY_W-1] || (r_day == '0);
    assign rem_inc  = (r_rem == YEAR_W'(LEAP_CYCLE - 1)) ? '0 : r_rem + YEAR_W'(1);
    assign rem_dec  = (r_rem == '0) ? YEAR_W'(LEAP_CYCLE - 1) : r_rem - YEAR_W'(1);

    // operand select for the shared adder
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                alu_a   = ACC_W'(i_day);
                alu_b   = ACC_W'(i_offs);
                alu_sub = 1'b0;
            end
            S_DIV: begin
                alu_a   = ACC_W'(r_rem);
                alu_b   = ACC_W'(LEAP_CYCLE) << r_qbit;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = ACC_W'(r_day);
                alu_b   = day_low ? ACC_W'(dim_prev) : ACC_W'(dim_cur);
                alu_sub = !day_low;
            end
        endcase
    end

    dad_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_sum  (alu_sum),
        .o_neg  (alu_neg),
        .o_zero (alu_zero)
    );

    assign fwd = !day_low && !alu_neg && !alu_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        if ((i_offs == '0) || (i_month > MON_DEC) || (i_day == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_qbit == '0) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (!day_low && !fwd) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_req.take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_year  <= ACC_W'(i_year);
                r_rem   <= i_year;
                r_qbit  <= QBIT_W'(Q_TOP);
                r_month <= i_month;
                r_day   <= alu_sum[WDAY_W-1:0];
                if (i_offs == '0) begin
                    r_res <= '{year: i_year, month: i_month, day: i_day, status: ST_OK};
                end else begin
                    r_res <= '{year: '0, month: '0, day: '0, status: ST_INVALID};
                end
            end
            S_DIV: begin
                // restoring remainder, one quotient bit a cycle
                if (!alu_neg) begin
                    r_rem <= alu_sum[YEAR_W-1:0];
                end
                r_qbit <= r_qbit - QBIT_W'(1);
            end
            S_WALK: begin
                if (day_low) begin
                    r_month <= prev_m;
                    r_day   <= alu_sum[WDAY_W-1:0];
                    if (r_month == MON_JAN) begin
                        r_year <= r_year - ACC_W'(1);
                        r_rem  <= rem_dec;
                    end
                end else if (fwd) begin
                    r_month <= next_m;
                    r_day   <= alu_sum[WDAY_W-1:0];
                    if (r_month == MON_DEC) begin
                        r_year <= r_year + ACC_W'(1);
                        r_rem  <= rem_inc;
                    end
                end else if (r_year < 0) begin
                    r_res <= '{year: '0, month: MON_JAN, day: DAY_W'(1), status: ST_RANGE};
                end else if (r_year > ACC_W'(YEAR_MAX)) begin
                    r_res <= '{year: YEAR_W'(YEAR_MAX), month: MON_DEC, day: DAY_W'(31),
                               status: ST_RANGE};
                end else begin
                    r_res <= '{year: r_year[YEAR_W-1:0], month: r_month,
                               day: r_day[DAY_W-1:0], status: ST_OK};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.ready = (r_state == S_IDLE);
    assign o_rsp.done  = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

FILE: rtl/core/date_add_days_top.sv
`timescale 1ns / 1ps
// path of an accepted input word to output valid: the year mod 400 remainder search, one month
// step per month crossed (n), one closing step, then the output register; n <= ~35
// zero offset or invalid date: straight from the accepted input word to the output register, no walk
// a new word is taken only once the last one has been handed over, which waits on output stalls;
// the remainder search and the walk run on the single shared adder in dad_seq
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid

module date_add_days_top import dad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dad_in_if.sink    i_in,
    dad_out_if.source o_out
);

    t_seq_req req;
    t_seq_rsp rsp;
    t_result  seq_res;

    // output holding register, decouples the sequencer from the downstream stall
    logic    r_out_valid;
    t_result r_out;

    // new word only when the sequencer is idle
    assign i_in.ready = rsp.ready;
    assign req.start  = i_in.valid && rsp.ready;
    // hand the finished word over once the output register is free or draining
    assign req.take   = rsp.done && (!r_out_valid || o_out.ready);

    dad_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_year  (i_in.start_year),
        .i_month (i_in.start_month),
        .i_day   (i_in.start_day),
        .i_offs  (i_in.day_offset),
        .o_rsp   (rsp),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req.take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (req.take) begin
            r_out <= seq_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_year  = r_out.year;
    assign o_out.result_month = r_out.month;
    assign o_out.result_day   = r_out.day;
    assign o_out.status       = r_out.status;

endmodule

FILE: tb/date_add_days_top_tb.sv
`timescale 1ns / 1ps

module date_add_days_top_tb;
    import dad_pkg::*;

    // one input word as the driver sees it
    typedef struct {
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic signed [OFFS_W-1:0] offset;
    } t_date_word;

    localparam int N_RANDOM   = 1525;
    localparam int DRAIN_WAIT = 60;   // a little over the longest walk

    logic i_clk;
    logic i_rst_n;

    dad_in_if  in_ch ();
    dad_out_if out_ch ();

    date_add_days_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_date_word pending_words[$];    // words not yet offered
    t_result    expected_dates[$];   // predicted results, oldest first
    t_date_word offered_word;        // word currently held on the input channel

    int error_count   = 0;
    int words_sent    = 0;
    int dates_checked = 0;
    int n_ok          = 0;
    int n_invalid     = 0;
    int n_range       = 0;

    int  send_gap  = 0;
    int  stall_cnt = 0;
    bit  send_calm = 0;   // stretch of back-to-back words
    bit  recv_calm = 0;   // stretch with ready held high

    // ---------------------------------------------------------------
    // prediction of the date stepper
    // ---------------------------------------------------------------

    // gregorian leap rule, shifted so years below zero follow the 400-year cycle
    function automatic bit is_leap_year(int y);
        int s;
        s = y + 4000;
        return (s % LEAP_CYCLE == 0) || ((s % CENTURY != 0) && (s % 4 == 0));
    endfunction

    function automatic int month_length(int y, int m);
        int lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == int'(MON_FEB) && is_leap_year(y))
            return 29;
        return lens[m];
    endfunction

    function automatic t_result step_date(t_date_word w);
        t_result r;
        int y;
        int m;
        int d;
        int offs;
        y    = int'(w.year);
        m    = int'(w.month);
        d    = int'(w.day);
        offs = int'(w.offset);
        r.status = ST_OK;

        // zero offset passes the date through untouched, even when it is bad
        if (offs == 0) begin
            r.year  = w.year;
            r.month = w.month;
            r.day   = w.day;
            return r;
        end
        if (m > int'(MON_DEC) || d < 1) begin
            r.year   = '0;
            r.month  = '0;
            r.day    = '0;
            r.status = ST_INVALID;
            return r;
        end

        // move the day, then walk month by month until it fits
        d += offs;
        while (d > month_length(y, m)) begin
            d -= month_length(y, m);
            m++;
            if (m > int'(MON_DEC)) begin
                m = int'(MON_JAN);
                y++;
            end
        end
        while (d < 1) begin
            if (m == int'(MON_JAN)) begin
                m = int'(MON_DEC);
                y--;
            end else begin
                m--;
            end
            d += month_length(y, m);
        end

        // saturate outside 0..9999
        if (y < 0) begin
            r.year   = '0;
            r.month  = MON_JAN;
            r.day    = DAY_W'(1);
            r.status = ST_RANGE;
        end else if (y > YEAR_MAX) begin
            r.year   = YEAR_W'(YEAR_MAX);
            r.month  = MON_DEC;
            r.day    = DAY_W'(31);
            r.status = ST_RANGE;
        end else begin
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DAY_W'(d);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_date_word make_word(int y, int m, int d, int o);
        t_date_word w;
        w.year   = YEAR_W'(y);
        w.month  = MONTH_W'(m);
        w.day    = DAY_W'(d);
        w.offset = OFFS_W'(o);
        return w;
    endfunction

    function automatic t_date_word random_word();
        t_date_word w;
        int pick;
        int ysel;
        pick = $urandom_range(99);
        ysel = $urandom_range(99);
        // mostly in-range years, with the ends of the range weighted up
        if (ysel < 8)
            w.year = YEAR_W'($urandom_range(3));
        else if (ysel < 16)
            w.year = YEAR_W'($urandom_range(YEAR_MAX, YEAR_MAX - 3));
        else
            w.year = YEAR_W'($urandom_range(YEAR_MAX));
        w.month = MONTH_W'($urandom_range(int'(MON_DEC)));
        w.day   = DAY_W'($urandom_range(31, 1));
        // short offsets hit month ends often, full span crosses many months
        if ($urandom_range(99) < 30)
            w.offset = OFFS_W'(int'($urandom_range(80)) - 40);
        else
            w.offset = OFFS_W'($urandom_range(2047));

        if (pick >= 80 && pick < 88) begin
            // year anywhere in the 14-bit field, beyond 9999 too
            w.year = YEAR_W'($urandom_range(16383));
        end else if (pick >= 88 && pick < 94) begin
            // mostly a bad month or day, with a nonzero offset
            w.year = YEAR_W'($urandom_range(16383));
            if ($urandom_range(1))
                w.month = MONTH_W'($urandom_range(15, 12));
            else
                w.day = '0;
            if ($urandom_range(3) == 0)
                w.month = MONTH_W'($urandom_range(15));
            if (w.offset == 0)
                w.offset = OFFS_W'(1);
        end else if (pick >= 94) begin
            // zero offset with any fields at all
            w.year   = YEAR_W'($urandom_range(16383));
            w.month  = MONTH_W'($urandom_range(15));
            w.day    = DAY_W'($urandom_range(31));
            w.offset = '0;
        end
        return w;
    endfunction

    // idle lengths: mostly short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ---------------------------------------------------------------
    // clock, reset and the run limit
    // ---------------------------------------------------------------

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.start_year   = '0;
        in_ch.start_month  = '0;
        in_ch.start_day    = '0;
        in_ch.day_offset   = '0;
        out_ch.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // worst case is well under a quarter of this
    initial begin
        #30ms;
        $display("timeout with %0d words sent and %0d results checked",
                 words_sent, dates_checked);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // driver: offers queued words, predicts each one at acceptance
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_dates.push_back(step_date(offered_word));
                words_sent <= words_sent + 1;
            end
            // the channel is free when nothing is offered or the word just went in
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    offered_word      = pending_words.pop_front();
                    in_ch.start_year  <= offered_word.year;
                    in_ch.start_month <= offered_word.month;
                    in_ch.start_day   <= offered_word.day;
                    in_ch.day_offset  <= offered_word.offset;
                    in_ch.valid       <= 1'b1;
                    if ($urandom_range(149) == 0)
                        send_calm = ~send_calm;
                    send_gap <= send_calm ? 0 : pick_idle();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random back-pressure, compares each result word
    // ---------------------------------------------------------------

    function automatic int compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int bad;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_cnt    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result word: year %0d month %0d day %0d status %0d",
                           out_ch.result_year, out_ch.result_month, out_ch.result_day,
                           out_ch.status);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_dates.pop_front();
                    bad  = compare_field("result_year", want.year, out_ch.result_year)
                         + compare_field("result_month", want.month, out_ch.result_month)
                         + compare_field("result_day", want.day, out_ch.result_day)
                         + compare_field("status", want.status, out_ch.status);
                    if (bad != 0)
                        error_count <= error_count + 1;
                    dates_checked <= dates_checked + 1;
                    case (want.status)
                        ST_OK:      n_ok      <= n_ok + 1;
                        ST_INVALID: n_invalid <= n_invalid + 1;
                        default:    n_range   <= n_range + 1;
                    endcase
                end
            end

            if ($urandom_range(299) == 0)
                recv_calm = ~recv_calm;
            if (stall_cnt != 0) begin
                stall_cnt    <= stall_cnt - 1;
                out_ch.ready <= 1'b0;
            end else if (!recv_calm && $urandom_range(99) < 20) begin
                stall_cnt    <= pick_idle();
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial begin
        int k;
        int n_total;

        // zero offset: passed through even when month, day or year are bad
        pending_words.push_back(make_word(16383, 15, 0, 0));
        pending_words.push_back(make_word(2024, 1, 29, 0));
        // bad month or day with a nonzero offset
        pending_words.push_back(make_word(2023, 12, 5, 1));
        pending_words.push_back(make_word(16383, 15, 31, -1024));
        pending_words.push_back(make_word(1999, 3, 0, 1023));
        // leap february under the 4, 100 and 400 rules
        pending_words.push_back(make_word(2024, 1, 28, 1));
        pending_words.push_back(make_word(1900, 1, 28, 1));
        pending_words.push_back(make_word(2000, 1, 28, 1));
        pending_words.push_back(make_word(2400, 1, 28, 1));
        pending_words.push_back(make_word(2100, 2, 1, -1));
        // day 31 of a short month runs on into the next or, stepped back, stays inside; december rolls over
        pending_words.push_back(make_word(2023, 1, 31, 1));
        pending_words.push_back(make_word(2023, 3, 31, 1));
        pending_words.push_back(make_word(2023, 3, 31, -1));
        pending_words.push_back(make_word(2023, 11, 31, 1));
        // year falls below zero: saturates low
        pending_words.push_back(make_word(0, 0, 1, -1));
        pending_words.push_back(make_word(0, 2, 1, -1024));
        // year 0 is a leap year in the walk
        pending_words.push_back(make_word(1, 0, 1, -366));
        pending_words.push_back(make_word(4, 0, 1, -1024));
        // year past 9999 at the end of the walk: saturates high
        pending_words.push_back(make_word(9999, 11, 31, 1));
        pending_words.push_back(make_word(16383, 5, 15, -1024));
        // start above 9999 that walks back into range
        pending_words.push_back(make_word(10000, 0, 1, -1));
        pending_words.push_back(make_word(10002, 0, 1, -1024));
        // offset extremes
        pending_words.push_back(make_word(1999, 0, 1, 1023));
        pending_words.push_back(make_word(2000, 2, 1, -1024));
        pending_words.push_back(make_word(2099, 11, 31, 1023));

        for (k = 0; k < N_RANDOM; k++)
            pending_words.push_back(random_word());
        n_total = pending_words.size();

        while (!i_rst_n)
            @(posedge i_clk);
        // every queued word has to come back checked
        while (dates_checked < n_total)
            @(posedge i_clk);
        // catch any stray word the block might still put out
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d date words, checked %0d results:", words_sent, dates_checked);
        $display("%0d ok, %0d bad input date, %0d out of range, %0d mismatching or unexpected",
                 n_ok, n_invalid, n_range, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
